>>> sv/pss_pkg.sv
package pss_pkg;

  // Longest string before the position counter wraps back to zero.
  localparam int MAX_TEXT_LEN = 4096;
  localparam int POS_W        = $clog2(MAX_TEXT_LEN);

  // Result queue between the scanner and the output port.
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  // Scanner phases.
  localparam logic [2:0] PH_TEXT   = 3'd0;
  localparam logic [2:0] PH_START  = 3'd1;
  localparam logic [2:0] PH_FLAGS  = 3'd2;
  localparam logic [2:0] PH_WIDTH  = 3'd3;
  localparam logic [2:0] PH_DOT    = 3'd4;
  localparam logic [2:0] PH_PREC   = 3'd5;
  localparam logic [2:0] PH_LENGTH = 3'd6;
  localparam logic [2:0] PH_HALT   = 3'd7;

  // Result kinds.
  localparam logic [1:0] KIND_SPEC     = 2'd0;
  localparam logic [1:0] KIND_DONE     = 2'd1;
  localparam logic [1:0] KIND_BAD_CONV = 2'd2;
  localparam logic [1:0] KIND_LEN_LONG = 2'd3;

  // Characters with a role of their own.
  localparam logic [7:0] CH_PCT  = 8'h25;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_DOT  = 8'h2E;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;

  // Length modifier words: first letter in the low byte, second above it.
  localparam logic [15:0] LW_NONE = 16'h0000;
  localparam logic [15:0] LW_HH   = 16'h6868;
  localparam logic [15:0] LW_H    = 16'h0068;
  localparam logic [15:0] LW_L    = 16'h006C;
  localparam logic [15:0] LW_LL   = 16'h6C6C;
  localparam logic [15:0] LW_J    = 16'h006A;
  localparam logic [15:0] LW_Z    = 16'h007A;
  localparam logic [15:0] LW_T    = 16'h0074;
  localparam logic [15:0] LW_BIGL = 16'h004C;
  localparam logic [15:0] LW_TWO  = 16'h0100;

  localparam logic [3:0] LC_NONE  = 4'd0;
  localparam logic [3:0] LC_HH    = 4'd1;
  localparam logic [3:0] LC_H     = 4'd2;
  localparam logic [3:0] LC_L     = 4'd3;
  localparam logic [3:0] LC_LL    = 4'd4;
  localparam logic [3:0] LC_J     = 4'd5;
  localparam logic [3:0] LC_Z     = 4'd6;
  localparam logic [3:0] LC_T     = 4'd7;
  localparam logic [3:0] LC_BIGL  = 4'd8;
  localparam logic [3:0] LC_OTHER = 4'd9;

  // Argument classes.
  localparam logic [4:0] AC_NONE       = 5'd0;
  localparam logic [4:0] AC_STR        = 5'd1;
  localparam logic [4:0] AC_DOUBLE     = 5'd2;
  localparam logic [4:0] AC_LONGDOUBLE = 5'd3;
  localparam logic [4:0] AC_SIZE       = 5'd4;
  localparam logic [4:0] AC_PTR        = 5'd5;
  localparam logic [4:0] AC_PTRDIFF    = 5'd6;
  localparam logic [4:0] AC_CHAR       = 5'd7;
  localparam logic [4:0] AC_UCHAR      = 5'd8;
  localparam logic [4:0] AC_USHORT     = 5'd9;
  localparam logic [4:0] AC_SHORT      = 5'd10;
  localparam logic [4:0] AC_UINT       = 5'd11;
  localparam logic [4:0] AC_INT        = 5'd12;
  localparam logic [4:0] AC_ULONG      = 5'd13;
  localparam logic [4:0] AC_LONG       = 5'd14;
  localparam logic [4:0] AC_LLONG      = 5'd15;
  localparam logic [4:0] AC_ULLONG     = 5'd16;

  localparam logic [15:0] DIG_MAX  = 16'hFFFF;
  localparam logic [11:0] SPEC_MAX = 12'hFFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [4:0]  flag_bits;
    logic [15:0] width_value;
    logic [15:0] precision_value;
    logic [1:0]  star_marks;
    logic [3:0]  length_code;
    logic [7:0]  conversion;
    logic [4:0]  arg_class;
    logic [11:0] begin_pos;
    logic [12:0] end_pos;
    logic [11:0] spec_total;
    logic [12:0] arg_total;
  } res_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_len(input logic [7:0] c);
    return (c == 8'h68) || (c == 8'h6C) || (c == 8'h6A) || (c == 8'h7A) ||
           (c == 8'h74) || (c == 8'h4C);
  endfunction

  function automatic logic is_int_signed(input logic [7:0] c);
    return (c == 8'h64) || (c == 8'h69);
  endfunction

  function automatic logic is_int_unsigned(input logic [7:0] c);
    return (c == 8'h75) || (c == 8'h6F) || (c == 8'h78) || (c == 8'h58);
  endfunction

  function automatic logic is_float(input logic [7:0] c);
    return (c == 8'h66) || (c == 8'h46) || (c == 8'h65) || (c == 8'h45) ||
           (c == 8'h67) || (c == 8'h47) || (c == 8'h61) || (c == 8'h41);
  endfunction

  function automatic logic is_conv(input logic [7:0] c);
    return is_int_signed(c) || is_int_unsigned(c) || is_float(c) ||
           (c == 8'h63) || (c == 8'h73) || (c == 8'h70) || (c == 8'h6E);
  endfunction

  function automatic logic [4:0] flag_bit(input logic [7:0] c);
    logic [4:0] f;
    case (c)
      8'h2D:   f = 5'h01;
      8'h2B:   f = 5'h02;
      8'h20:   f = 5'h04;
      8'h23:   f = 5'h08;
      8'h30:   f = 5'h10;
      default: f = 5'h00;
    endcase
    return f;
  endfunction

  // One decimal digit into a saturating 16-bit accumulator.
  function automatic logic [15:0] acc_digit(input logic [15:0] v, input logic [7:0] c);
    logic [19:0] n;
    n = ({4'b0, v} << 3) + ({4'b0, v} << 1) + {16'b0, c[3:0]};
    return (n > {4'b0, DIG_MAX}) ? DIG_MAX : n[15:0];
  endfunction

  function automatic logic [3:0] len_code(input logic [15:0] w);
    logic [3:0] lc;
    case (w)
      LW_NONE: lc = LC_NONE;
      LW_HH:   lc = LC_HH;
      LW_H:    lc = LC_H;
      LW_L:    lc = LC_L;
      LW_LL:   lc = LC_LL;
      LW_J:    lc = LC_J;
      LW_Z:    lc = LC_Z;
      LW_T:    lc = LC_T;
      LW_BIGL: lc = LC_BIGL;
      default: lc = LC_OTHER;
    endcase
    return lc;
  endfunction

  function automatic logic [4:0] signed_class(input logic [3:0] lc);
    logic [4:0] a;
    case (lc)
      LC_NONE: a = AC_INT;
      LC_HH:   a = AC_CHAR;
      LC_H:    a = AC_SHORT;
      LC_L:    a = AC_LONG;
      LC_LL:   a = AC_LLONG;
      LC_J:    a = AC_LLONG;
      LC_Z:    a = AC_SIZE;
      LC_T:    a = AC_PTRDIFF;
      default: a = AC_NONE;
    endcase
    return a;
  endfunction

  function automatic logic [4:0] unsigned_class(input logic [3:0] lc);
    logic [4:0] a;
    case (lc)
      LC_NONE: a = AC_UINT;
      LC_HH:   a = AC_UCHAR;
      LC_H:    a = AC_USHORT;
      LC_L:    a = AC_ULONG;
      LC_LL:   a = AC_ULLONG;
      LC_J:    a = AC_ULLONG;
      LC_Z:    a = AC_SIZE;
      LC_T:    a = AC_PTRDIFF;
      default: a = AC_NONE;
    endcase
    return a;
  endfunction

  function automatic logic [4:0] arg_class_of(input logic [7:0] c, input logic [3:0] lc);
    logic [4:0] a;
    a = AC_NONE;
    if (is_int_signed(c)) begin
      a = signed_class(lc);
    end else if (is_int_unsigned(c)) begin
      a = unsigned_class(lc);
    end else if (is_float(c)) begin
      a = (lc == LC_NONE) ? AC_DOUBLE : ((lc == LC_BIGL) ? AC_LONGDOUBLE : AC_NONE);
    end else if (c == 8'h63) begin
      a = (lc == LC_NONE) ? AC_CHAR : AC_NONE;
    end else if (c == 8'h73) begin
      a = (lc == LC_NONE) ? AC_STR : AC_NONE;
    end else if (c == 8'h70) begin
      a = (lc == LC_NONE) ? AC_PTR : AC_NONE;
    end
    return a;
  endfunction

endpackage

>>> sv/printf_spec_scanner_unit.sv
// Channel   Direction  Payload                                    Marker
// in_*      slave      tdata[7:0] text_byte                       tlast = final_byte
// out_*     master     tdata: spec fields, positions and totals   tuser[1:0] = kind
//
// One byte is taken per cycle while in_tready is high; its whole state update is done in the cycle of the transfer.
// Each byte yields zero, one or two results, which wait in a four-entry result queue.
// in_tready is high while the queue has room for two results, so a stalled output side
// backs up the input once three or four results wait; bytes without a result never fill it.
// A result shows on the output in the cycle after its byte's transfer at the earliest.
// rst_n is synchronous and active low; it empties the queue and returns the scanner to text.
module printf_spec_scanner_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] text_byte
  input  logic         in_tlast,   // final_byte
  output logic         out_tvalid,
  input  logic         out_tready,
  // [4:0] flag_bits, [20:5] width_value, [36:21] precision_value, [38:37] star_marks,
  // [42:39] length_code, [50:43] conversion, [55:51] arg_class, [67:56] begin_pos,
  // [80:68] end_pos, [92:81] spec_total, [105:93] arg_total, [111:106] zero
  output logic [111:0] out_tdata,
  output logic [1:0]   out_tuser   // [1:0] kind
);
  import pss_pkg::*;

  // Scanner state.
  logic [2:0]       phase_r, phase_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] sstart_r, sstart_nxt;
  logic [4:0]       flag_r, flag_nxt;
  logic [15:0]      wid_r, wid_nxt;
  logic [15:0]      prec_r, prec_nxt;
  logic [1:0]       star_r, star_nxt;
  logic [15:0]      lw_r, lw_nxt;
  logic [11:0]      scnt_r, scnt_nxt;
  logic [12:0]      acnt_r, acnt_nxt;

  // Result queue.
  res_t             fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic             in_fire, out_fire;
  logic [7:0]       c;
  logic             byte_v, fin_v, err;
  res_t             byte_res, fin_res, slot0, slot1;
  logic             push0, push1;
  logic [13:0]      asum;
  logic [3:0]       lc;

  assign c         = in_tdata;
  assign in_tready = (count_r <= CNT_W'(FIFO_DEPTH - 2));
  assign in_fire   = in_tvalid && in_tready;
  assign out_tvalid = (count_r != '0);
  assign out_fire  = out_tvalid && out_tready;
  assign lc        = len_code(lw_r);
  assign asum      = {1'b0, acnt_r} + 14'd1 + {13'b0, star_r[0]} + {13'b0, star_r[1]};

  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    sstart_nxt = sstart_r;
    flag_nxt   = flag_r;
    wid_nxt    = wid_r;
    prec_nxt   = prec_r;
    star_nxt   = star_r;
    lw_nxt     = lw_r;
    scnt_nxt   = scnt_r;
    acnt_nxt   = acnt_r;
    byte_v     = 1'b0;
    fin_v      = 1'b0;
    err        = 1'b0;
    byte_res   = '0;
    fin_res    = '0;
    if (in_fire) begin
      case (phase_r)
        PH_TEXT: begin
          if (c == CH_PCT) begin
            flag_nxt   = '0;
            wid_nxt    = '0;
            prec_nxt   = '0;
            star_nxt   = '0;
            lw_nxt     = '0;
            sstart_nxt = pos_r;
            phase_nxt  = PH_START;
          end
        end
        PH_HALT: begin
        end
        default: begin
          if (phase_r == PH_START && c == CH_PCT) begin
            // A doubled percent sign is plain text.
            phase_nxt = PH_TEXT;
          end else if (phase_r <= PH_FLAGS && flag_bit(c) != '0) begin
            flag_nxt  = flag_r | flag_bit(c);
            phase_nxt = PH_FLAGS;
          end else if (phase_r <= PH_FLAGS && c == CH_STAR) begin
            star_nxt  = star_r | 2'b01;
            phase_nxt = PH_WIDTH;
          end else if (phase_r <= PH_FLAGS && is_digit(c)) begin
            wid_nxt   = acc_digit(16'd0, c);
            phase_nxt = PH_WIDTH;
          end else if (phase_r == PH_WIDTH && is_digit(c) && !star_r[0]) begin
            wid_nxt = acc_digit(wid_r, c);
          end else if (phase_r <= PH_WIDTH && c == CH_DOT) begin
            phase_nxt = PH_DOT;
          end else if (phase_r == PH_DOT && c == CH_STAR) begin
            star_nxt  = star_r | 2'b10;
            phase_nxt = PH_PREC;
          end else if (phase_r == PH_DOT && is_digit(c)) begin
            prec_nxt  = acc_digit(16'd0, c);
            phase_nxt = PH_PREC;
          end else if (phase_r == PH_PREC && is_digit(c) && !star_r[1]) begin
            prec_nxt = acc_digit(prec_r, c);
          end else if (is_len(c)) begin
            if (lw_r > LW_TWO) begin
              // A third length letter.
              byte_v             = 1'b1;
              byte_res.kind      = KIND_LEN_LONG;
              byte_res.begin_pos = 12'(sstart_r);
              byte_res.end_pos   = 13'(pos_r);
              phase_nxt          = PH_HALT;
            end else begin
              lw_nxt    = (lw_r == '0) ? {8'b0, c} : (lw_r | {c, 8'b0});
              phase_nxt = PH_LENGTH;
            end
          end else if (!is_conv(c)) begin
            byte_v             = 1'b1;
            byte_res.kind      = KIND_BAD_CONV;
            byte_res.begin_pos = 12'(sstart_r);
            byte_res.end_pos   = 13'(pos_r);
            phase_nxt          = PH_HALT;
          end else begin
            byte_v                   = 1'b1;
            byte_res.kind            = KIND_SPEC;
            byte_res.flag_bits       = flag_r;
            byte_res.width_value     = wid_r;
            byte_res.precision_value = prec_r;
            byte_res.star_marks      = star_r;
            byte_res.length_code     = lc;
            byte_res.conversion      = c;
            byte_res.arg_class       = arg_class_of(c, lc);
            byte_res.begin_pos       = 12'(sstart_r);
            byte_res.end_pos         = 13'(pos_r) + 13'd1;
            scnt_nxt  = (scnt_r == SPEC_MAX) ? scnt_r : scnt_r + 12'd1;
            acnt_nxt  = asum[13] ? 13'h1FFF : asum[12:0];
            phase_nxt = PH_TEXT;
          end
        end
      endcase
      err     = (phase_nxt == PH_HALT);
      pos_nxt = (pos_r == POS_W'(MAX_TEXT_LEN - 1)) ? '0 : pos_r + POS_W'(1);
      if (in_tlast) begin
        if (!err) begin
          fin_v = 1'b1;
          if (phase_nxt != PH_TEXT) begin
            // The string ended inside a spec.
            fin_res.kind      = KIND_BAD_CONV;
            fin_res.begin_pos = 12'(sstart_nxt);
            fin_res.end_pos   = 13'(pos_r) + 13'd1;
          end else begin
            fin_res.kind       = KIND_DONE;
            fin_res.end_pos    = 13'(pos_r) + 13'd1;
            fin_res.spec_total = scnt_nxt;
            fin_res.arg_total  = acnt_nxt;
          end
        end
        phase_nxt  = PH_TEXT;
        pos_nxt    = '0;
        sstart_nxt = '0;
        flag_nxt   = '0;
        wid_nxt    = '0;
        prec_nxt   = '0;
        star_nxt   = '0;
        lw_nxt     = '0;
        scnt_nxt   = '0;
        acnt_nxt   = '0;
      end
    end
  end

  // Results enter the queue packed: the byte's own result first, then the end-of-string one.
  assign slot0 = byte_v ? byte_res : fin_res;
  assign slot1 = fin_res;
  assign push0 = byte_v || fin_v;
  assign push1 = byte_v && fin_v;

  assign count_nxt = count_r + CNT_W'(push0) + CNT_W'(push1) - CNT_W'(out_fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_TEXT;
      pos_r    <= '0;
      sstart_r <= '0;
      flag_r   <= '0;
      wid_r    <= '0;
      prec_r   <= '0;
      star_r   <= '0;
      lw_r     <= '0;
      scnt_r   <= '0;
      acnt_r   <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      sstart_r <= sstart_nxt;
      flag_r   <= flag_nxt;
      wid_r    <= wid_nxt;
      prec_r   <= prec_nxt;
      star_r   <= star_nxt;
      lw_r     <= lw_nxt;
      scnt_r   <= scnt_nxt;
      acnt_r   <= acnt_nxt;
      wr_ptr_r <= wr_ptr_r + PTR_W'(push0) + PTR_W'(push1);
      rd_ptr_r <= rd_ptr_r + PTR_W'(out_fire);
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push0) begin
      fifo_r[wr_ptr_r] <= slot0;
    end
    if (push1) begin
      fifo_r[wr_ptr_r + PTR_W'(1)] <= slot1;
    end
  end

  res_t head;
  assign head      = fifo_r[rd_ptr_r];
  assign out_tuser = head.kind;
  assign out_tdata = {6'b0, head.arg_total, head.spec_total, head.end_pos, head.begin_pos,
                      head.arg_class, head.conversion, head.length_code, head.star_marks,
                      head.precision_value, head.width_value, head.flag_bits};

  // The queue never holds more entries than it has.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  // Two results from one byte only happen on the last byte of a string.
  a_two_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    push1 |-> in_tlast)
    else $error("two results from a byte that does not end the string");

  // The end of a string returns the scanner to text with cleared totals.
  a_final_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tlast) |=> (phase_r == PH_TEXT && scnt_r == '0 && acnt_r == '0))
    else $error("scanner not back to text after the final byte");

  // Every spec needs at least one argument, so the argument total never trails the spec total.
  a_args_cover_specs: assert property (@(posedge clk) disable iff (!rst_n)
    acnt_r >= {1'b0, scnt_r})
    else $error("argument total below spec total");

endmodule
